### rtl/core/rbsm_pkg.sv
// Shared constants and operation codes for the sign-magnitude register bank ALU.
package rbsm_pkg;

  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 3;
  localparam int PORT_MAG_W = 64;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 2'd3;

endpackage

### rtl/core/rbsm_if.sv
// Command and response channel interfaces for the sign-magnitude register bank ALU.
interface rbsm_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [rbsm_pkg::FUNC_W-1:0]       func;
  logic [rbsm_pkg::IDX_W-1:0]        first_index;
  logic [rbsm_pkg::IDX_W-1:0]        second_index;
  logic [rbsm_pkg::PORT_MAG_W-1:0]   load_value;

  modport source (output valid, func, first_index, second_index, load_value, input ready);
  modport sink   (input valid, func, first_index, second_index, load_value, output ready);
endinterface

interface rbsm_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rbsm_pkg::IDX_W-1:0]        dest_index;
  logic [rbsm_pkg::PORT_MAG_W-1:0]   magnitude;
  logic                              negative;
  logic                              overflow;
  logic                              bank_full;

  modport source (output valid, dest_index, magnitude, negative, overflow, bank_full,
                  input ready);
  modport sink   (input valid, dest_index, magnitude, negative, overflow, bank_full,
                  output ready);
endinterface

### rtl/core/rbsm_adder.sv
// Shared add/subtract unit with carry out, used by add, subtract and multiply steps.
module rbsm_adder #(
  parameter int MAG_WIDTH = 64
) (
  input  logic [MAG_WIDTH-1:0] x,
  input  logic [MAG_WIDTH-1:0] y,
  input  logic                 sub,
  output logic [MAG_WIDTH-1:0] sum,
  output logic                 carry
);

  localparam int SumW = MAG_WIDTH + 1;

  logic [MAG_WIDTH-1:0] y_eff;

  // Subtract as x + ~y + 1; carry out high means x >= y.
  assign y_eff = sub ? ~y : y;
  assign {carry, sum} = SumW'(x) + SumW'(y_eff) + SumW'(sub);

endmodule

### rtl/core/rbsm_bank.sv
// Magnitude storage: one write port, one registered read port.
module rbsm_bank #(
  parameter int NUM_SLOTS = 8,
  parameter int MAG_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(NUM_SLOTS)-1:0] waddr,
  input  logic [MAG_WIDTH-1:0]         wdata,
  input  logic [$clog2(NUM_SLOTS)-1:0] raddr,
  output logic [MAG_WIDTH-1:0]         rdata
);

  logic [MAG_WIDTH-1:0] mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/register_bank_sign_magnitude_alu_unit.sv
// From command beat to response, a load goes S_IDLE, S_FIN; add, subtract and multiply go
// S_IDLE, S_RDA, S_RDB, S_OPB, S_RUN, S_FIN. Subtract repeats S_RUN once after a borrow;
// multiply takes MAG_WIDTH shift-add steps in S_RUN, one per cycle through the shared adder.
// One command at a time, taken only in S_IDLE; S_FIN holds while a response is stalled.
// Reset (rst, synchronous) clears the sequencer, the load count and the response valid;
// bank contents are not cleared and read as unknown until loaded.
module register_bank_sign_magnitude_alu_unit #(
  parameter int NUM_SLOTS = 8,
  parameter int MAG_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  rbsm_cmd_if.sink   cmd,
  rbsm_rsp_if.source rsp
);

  localparam int SlotW = $clog2(NUM_SLOTS);
  localparam int CntW  = $clog2(NUM_SLOTS + 1);
  localparam int StepW = $clog2(MAG_WIDTH);
  localparam int IdxW  = rbsm_pkg::IDX_W;
  localparam int PortW = rbsm_pkg::PORT_MAG_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_OPB  = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                  state;
  logic [rbsm_pkg::FUNC_W-1:0] func_r;
  logic [SlotW-1:0]            ia;
  logic [SlotW-1:0]            ib;
  logic [MAG_WIDTH-1:0]        opa;
  logic [MAG_WIDTH-1:0]        opb;
  logic [MAG_WIDTH-1:0]        acc;
  logic [MAG_WIDTH-1:0]        mplier;
  logic [StepW-1:0]            step;
  logic                        swap;
  logic [CntW-1:0]             load_count;

  logic [SlotW-1:0]            res_dest;
  logic [MAG_WIDTH-1:0]        res_mag;
  logic                        res_neg;
  logic                        res_ovf;
  logic                        res_full;
  logic                        res_we;

  logic                        out_valid;
  logic [SlotW-1:0]            out_dest;
  logic [MAG_WIDTH-1:0]        out_mag;
  logic                        out_neg;
  logic                        out_ovf;
  logic                        out_full;

  logic [SlotW-1:0]            rd_addr;
  logic [MAG_WIDTH-1:0]        rd_data;
  logic [MAG_WIDTH-1:0]        add_x;
  logic [MAG_WIDTH-1:0]        add_y;
  logic                        add_sub;
  logic [MAG_WIDTH-1:0]        add_sum;
  logic                        add_carry;
  logic [MAG_WIDTH:0]          hi;
  logic                        fin_fire;

  // Reduce a 3-bit slot number modulo the bank depth.
  function automatic logic [SlotW-1:0] wrap_idx(input logic [IdxW-1:0] idx);
    logic [4:0] v;
    v = 5'(idx);
    for (int i = 0; i < 8; i++) begin
      if (v >= 5'(NUM_SLOTS)) begin
        v = v - 5'(NUM_SLOTS);
      end
    end
    return SlotW'(v);
  endfunction

  rbsm_adder #(.MAG_WIDTH(MAG_WIDTH)) u_adder (
    .x     (add_x),
    .y     (add_y),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  rbsm_bank #(.NUM_SLOTS(NUM_SLOTS), .MAG_WIDTH(MAG_WIDTH)) u_bank (
    .clk   (clk),
    .we    (fin_fire && res_we),
    .waddr (res_dest),
    .wdata (res_mag),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign cmd.ready = (state == S_IDLE);
  assign fin_fire  = (state == S_FIN) && (!out_valid || rsp.ready);
  assign rd_addr   = (state == S_RDB) ? ib : ia;

  always_comb begin
    add_x   = opa;
    add_y   = opb;
    add_sub = 1'b0;
    unique case (func_r)
      rbsm_pkg::FUNC_LOAD, rbsm_pkg::FUNC_ADD: begin
      end
      rbsm_pkg::FUNC_SUB: begin
        add_sub = 1'b1;
        if (swap) begin
          add_x = opb;
          add_y = opa;
        end
      end
      rbsm_pkg::FUNC_MUL: begin
        add_x = acc;
        add_y = opa;
      end
    endcase
  end

  // Partial product high half after this step, before the shift.
  assign hi = mplier[0] ? {add_carry, add_sum} : {1'b0, acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            func_r <= cmd.func;
            ia     <= wrap_idx(cmd.first_index);
            ib     <= wrap_idx(cmd.second_index);
            if (cmd.func == rbsm_pkg::FUNC_LOAD) begin
              res_neg <= 1'b0;
              res_ovf <= 1'b0;
              if (load_count == CntW'(NUM_SLOTS)) begin
                res_full <= 1'b1;
                res_we   <= 1'b0;
                res_dest <= '0;
                res_mag  <= '0;
              end else begin
                res_full <= 1'b0;
                res_we   <= 1'b1;
                res_dest <= load_count[SlotW-1:0];
                res_mag  <= cmd.load_value[MAG_WIDTH-1:0];
              end
              state <= S_FIN;
            end else begin
              state <= S_RDA;
            end
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          opa   <= rd_data;
          state <= S_OPB;
        end
        S_OPB: begin
          opb      <= rd_data;
          mplier   <= rd_data;
          acc      <= '0;
          step     <= '0;
          swap     <= 1'b0;
          res_full <= 1'b0;
          res_we   <= 1'b1;
          res_dest <= (ia < ib) ? ia : ib;
          state    <= S_RUN;
        end
        S_RUN: begin
          unique case (func_r)
            rbsm_pkg::FUNC_LOAD: begin
              state <= S_FIN;
            end
            rbsm_pkg::FUNC_ADD: begin
              res_mag <= add_sum;
              res_ovf <= add_carry;
              res_neg <= 1'b0;
              state   <= S_FIN;
            end
            rbsm_pkg::FUNC_SUB: begin
              res_ovf <= 1'b0;
              // Borrow on the first pass: redo as second minus first.
              if (!swap && !add_carry) begin
                swap <= 1'b1;
              end else begin
                res_mag <= add_sum;
                res_neg <= swap;
                state   <= S_FIN;
              end
            end
            rbsm_pkg::FUNC_MUL: begin
              acc    <= hi[MAG_WIDTH:1];
              mplier <= {hi[0], mplier[MAG_WIDTH-1:1]};
              step   <= step + 1'b1;
              if (step == StepW'(MAG_WIDTH - 1)) begin
                res_mag <= {hi[0], mplier[MAG_WIDTH-1:1]};
                res_ovf <= |hi[MAG_WIDTH:1];
                res_neg <= 1'b0;
                state   <= S_FIN;
              end
            end
          endcase
        end
        S_FIN: begin
          if (fin_fire) begin
            state <= S_IDLE;
            if (res_we && (func_r == rbsm_pkg::FUNC_LOAD)) begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_dest <= res_dest;
      out_mag  <= res_mag;
      out_neg  <= res_neg;
      out_ovf  <= res_ovf;
      out_full <= res_full;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.dest_index = IdxW'(out_dest);
  assign rsp.magnitude  = PortW'(out_mag);
  assign rsp.negative   = out_neg;
  assign rsp.overflow   = out_ovf;
  assign rsp.bank_full  = out_full;

endmodule

### rtl/core/rbsm_checker.sv
// Port-level assertions for the sign-magnitude register bank ALU, bound to the top level.
module rbsm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [rbsm_pkg::IDX_W-1:0]      rsp_dest_index,
  input logic [rbsm_pkg::PORT_MAG_W-1:0] rsp_magnitude,
  input logic                            rsp_negative,
  input logic                            rsp_overflow,
  input logic                            rsp_bank_full
);

  a_reset_no_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // A command beat starts a multi-cycle operation.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command taken again one cycle after a beat");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_magnitude)
                                   && $stable(rsp_dest_index)))
    else $error("stalled response changed");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_bank_full) |-> (rsp_dest_index == '0 && rsp_magnitude == '0
                                      && !rsp_negative && !rsp_overflow))
    else $error("bank-full response carries data");

  // Negative only from a subtract with a strictly larger second operand.
  a_negative_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_negative) |-> (!rsp_overflow && rsp_magnitude != '0))
    else $error("negative response with overflow or zero magnitude");

endmodule

bind register_bank_sign_magnitude_alu_unit rbsm_checker u_rbsm_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_dest_index (rsp.dest_index),
  .rsp_magnitude  (rsp.magnitude),
  .rsp_negative   (rsp.negative),
  .rsp_overflow   (rsp.overflow),
  .rsp_bank_full  (rsp.bank_full)
);

### sim/register_bank_sign_magnitude_alu_unit_test.sv
// Self-checking testbench for the sign-magnitude register bank ALU unit.
`timescale 1ns / 1ps

module register_bank_sign_magnitude_alu_unit_test;

  localparam int FUNC_W      = rbsm_pkg::FUNC_W;
  localparam int IDX_W       = rbsm_pkg::IDX_W;
  localparam int PORT_MAG_W  = rbsm_pkg::PORT_MAG_W;
  localparam int NUM_SLOTS   = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [IDX_W-1:0]      dest_index;
    logic [PORT_MAG_W-1:0] magnitude;
    logic                  negative;
    logic                  overflow;
    logic                  bank_full;
  } alu_result_t;

  logic clk;
  logic rst;

  rbsm_cmd_if cmd();
  rbsm_rsp_if rsp();

  register_bank_sign_magnitude_alu_unit #(
    .NUM_SLOTS(NUM_SLOTS),
    .MAG_WIDTH(PORT_MAG_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // Predicted bank contents
  logic [PORT_MAG_W-1:0] slot_mag [NUM_SLOTS];
  logic                  slot_neg [NUM_SLOTS];
  int                    slots_loaded;

  alu_result_t expected_results [$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Update the predicted bank for one command and return the result it produces.
  function automatic alu_result_t next_alu_result(input logic [FUNC_W-1:0] func,
                                                  input logic [IDX_W-1:0] first,
                                                  input logic [IDX_W-1:0] second,
                                                  input logic [PORT_MAG_W-1:0] value);
    alu_result_t           res;
    logic [PORT_MAG_W-1:0] a;
    logic [PORT_MAG_W-1:0] b;
    logic [PORT_MAG_W:0]   sum;
    logic [2*PORT_MAG_W-1:0] prod;
    int                    ia;
    int                    ib;
    int                    lo;
    res = '0;
    if (func == rbsm_pkg::FUNC_LOAD) begin
      if (slots_loaded >= NUM_SLOTS) begin
        res.bank_full = 1'b1;
      end else begin
        slot_mag[slots_loaded] = value;
        slot_neg[slots_loaded] = 1'b0;
        res.dest_index = slots_loaded[IDX_W-1:0];
        res.magnitude = value;
        slots_loaded++;
      end
      return res;
    end
    ia = int'(first) % NUM_SLOTS;
    ib = int'(second) % NUM_SLOTS;
    lo = (ia < ib) ? ia : ib;
    a = slot_mag[ia];
    b = slot_mag[ib];
    case (func)
      rbsm_pkg::FUNC_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        res.magnitude = sum[PORT_MAG_W-1:0];
        res.overflow = sum[PORT_MAG_W];
      end
      rbsm_pkg::FUNC_SUB: begin
        if (a >= b) begin
          res.magnitude = a - b;
        end else begin
          res.magnitude = b - a;
          res.negative = 1'b1;
        end
      end
      default: begin
        prod = {{PORT_MAG_W{1'b0}}, a} * {{PORT_MAG_W{1'b0}}, b};
        res.magnitude = prod[PORT_MAG_W-1:0];
        res.overflow = |prod[2*PORT_MAG_W-1:PORT_MAG_W];
      end
    endcase
    slot_mag[lo] = res.magnitude;
    slot_neg[lo] = res.negative;
    res.dest_index = lo[IDX_W-1:0];
    return res;
  endfunction

  task automatic send_command(input logic [FUNC_W-1:0] func,
                              input logic [IDX_W-1:0] first,
                              input logic [IDX_W-1:0] second,
                              input logic [PORT_MAG_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.func         <= func;
    cmd.first_index  <= first;
    cmd.second_index <= second;
    cmd.load_value   <= value;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    expected_results.push_back(next_alu_result(func, first, second, value));
  endtask

  task automatic wait_for_results();
    cmd.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [PORT_MAG_W-1:0] got,
                                 input logic [PORT_MAG_W-1:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    alu_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected beat, magnitude", rsp.magnitude, '0);
      return;
    end
    want = expected_results.pop_front();
    if (rsp.dest_index !== want.dest_index)
      report_mismatch("dest_index", PORT_MAG_W'(rsp.dest_index),
                      PORT_MAG_W'(want.dest_index));
    if (rsp.magnitude !== want.magnitude)
      report_mismatch("magnitude", rsp.magnitude, want.magnitude);
    if (rsp.negative !== want.negative)
      report_mismatch("negative", PORT_MAG_W'(rsp.negative), PORT_MAG_W'(want.negative));
    if (rsp.overflow !== want.overflow)
      report_mismatch("overflow", PORT_MAG_W'(rsp.overflow), PORT_MAG_W'(want.overflow));
    if (rsp.bank_full !== want.bank_full)
      report_mismatch("bank_full", PORT_MAG_W'(rsp.bank_full),
                      PORT_MAG_W'(want.bank_full));
  endtask

  // Receiver: check each accepted beat, then pick ready for the next edge.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) check_result();
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("register_bank_sign_magnitude_alu_unit_test failed");
        $finish;
      end
    end
  end

  function automatic logic [PORT_MAG_W-1:0] random_magnitude();
    logic [PORT_MAG_W-1:0] v;
    case ($urandom_range(3))
      0: v = '1;
      1: v = '0;
      2: v = {{(PORT_MAG_W-1){1'b0}}, 1'b1} << $urandom_range(PORT_MAG_W-1);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Fill the bank with edge values, hit each operation and the full-bank load.
  // Every operand slot is loaded before it is read.
  task automatic test_load_and_arith_edges();
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, '1);
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, 64'd1);
    send_command(rbsm_pkg::FUNC_SUB, 3'd1, 3'd0, '0);   // first smaller: negative
    send_command(rbsm_pkg::FUNC_ADD, 3'd0, 3'd1, '0);   // negative operand, sign ignored
    send_command(rbsm_pkg::FUNC_ADD, 3'd1, 3'd0, '0);   // wraps to zero with overflow
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, '0);
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, 64'h8000_0000_0000_0000);
    send_command(rbsm_pkg::FUNC_MUL, 3'd3, 3'd3, '0);   // same slot twice, overflow
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, 64'h0000_0000_FFFF_FFFF);
    send_command(rbsm_pkg::FUNC_MUL, 3'd4, 3'd4, '0);   // largest square that fits
    send_command(rbsm_pkg::FUNC_MUL, 3'd4, 3'd1, '0);
    send_command(rbsm_pkg::FUNC_MUL, 3'd2, 3'd1, '0);   // times zero
    send_command(rbsm_pkg::FUNC_SUB, 3'd4, 3'd4, '0);   // equal magnitudes
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, 64'h5555_5555_5555_5555);
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_command(rbsm_pkg::FUNC_SUB, 3'd5, 3'd6, '0);
    send_command(rbsm_pkg::FUNC_SUB, 3'd6, 3'd5, '0);   // result clears the sign
    send_command(rbsm_pkg::FUNC_MUL, 3'd6, 3'd5, '0);
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, 64'h0123_4567_89AB_CDEF);
    send_command(rbsm_pkg::FUNC_LOAD, 3'd7, 3'd7, '1);  // bank already full: bank_full
    send_command(rbsm_pkg::FUNC_LOAD, 3'd0, 3'd0, '0);
    send_command(rbsm_pkg::FUNC_ADD, 3'd7, 3'd6, '0);
    send_command(rbsm_pkg::FUNC_SUB, 3'd6, 3'd7, '0);
    wait_for_results();
  endtask

  // Arithmetic on a full bank, with some loads that must report a full bank.
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  second;
    int                pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      pick   = $urandom_range(99);
      first  = IDX_W'($urandom_range(NUM_SLOTS-1));
      second = IDX_W'($urandom_range(NUM_SLOTS-1));
      if (pick < 10) func = rbsm_pkg::FUNC_LOAD;
      else if (pick < 45) func = rbsm_pkg::FUNC_ADD;
      else if (pick < 80) func = rbsm_pkg::FUNC_SUB;
      else func = rbsm_pkg::FUNC_MUL;
      // Slot 7 is only rewritten by itself; keep it odd so the bank never decays to zero
      if (first == 3'd7 && second == 3'd7 && func != rbsm_pkg::FUNC_LOAD)
        func = rbsm_pkg::FUNC_MUL;
      send_command(func, first, second, random_magnitude());
    end
    wait_for_results();
  endtask

  initial begin
    mismatch_count   = 0;
    slots_loaded     = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_mag[i] = '0;
      slot_neg[i] = 1'b0;
    end
    rst              <= 1'b1;
    cmd.valid        <= 1'b0;
    cmd.func         <= rbsm_pkg::FUNC_LOAD;
    cmd.first_index  <= '0;
    cmd.second_index <= '0;
    cmd.load_value   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_and_arith_edges();
    test_random_traffic(330, 0, 0);
    test_random_traffic(330, 59, 0);
    test_random_traffic(330, 0, 59);
    test_random_traffic(330, 15, 15);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("register_bank_sign_magnitude_alu_unit_test passed");
    else
      $display("register_bank_sign_magnitude_alu_unit_test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/rbsm_pkg.sv
rtl/core/rbsm_if.sv
rtl/core/rbsm_adder.sv
rtl/core/rbsm_bank.sv
rtl/core/register_bank_sign_magnitude_alu_unit.sv
rtl/core/rbsm_checker.sv
sim/register_bank_sign_magnitude_alu_unit_test.sv
